// ----- rtl/level_follow_hysteresis_stepper_unit_defines.svh -----
// Assertion macros shared by the level follower RTL.
`ifndef LEVEL_FOLLOW_HYSTERESIS_STEPPER_UNIT_DEFINES_SVH
`define LEVEL_FOLLOW_HYSTERESIS_STEPPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge while out of reset.
`define LFHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define LFHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define LFHS_ASSERT(lbl, prop, msg)
`define LFHS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/lfhs_pkg.sv -----
// Types, register indexes and reset values of the level follower.
`default_nettype none

package lfhs_pkg;

    // Field widths
    localparam int CAP_W     = 24;
    localparam int THR_W     = 20;
    localparam int LOST_W    = 16;
    localparam int STEP_W    = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_THRESHOLD    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LIMIT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SMALL       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MEDIUM      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_BIG         = 4'd7;

    // Reset values
    localparam logic [CAP_W-1:0]  RST_SATURATION_LIMIT = 24'd9999000;
    localparam logic [LOST_W-1:0] RST_LOST_LIMIT       = 16'd20;
    localparam logic [STEP_W-1:0] RST_STEP_SMALL       = 8'd2;
    localparam logic [STEP_W-1:0] RST_STEP_MEDIUM      = 8'd10;
    localparam logic [STEP_W-1:0] RST_STEP_BIG         = 8'd50;
    localparam logic [LOST_W-1:0] LOST_MAX             = 16'hFFFF;

    typedef enum logic [1:0] {
        REGION_SATURATED = 2'd0,
        REGION_ABOVE     = 2'd1,
        REGION_BELOW     = 2'd2,
        REGION_STABLE    = 2'd3
    } region_t;

    typedef struct packed {
        logic [LOST_W-1:0] lost_level;
        logic              rescan_request;
        logic [STEP_W-1:0] step_length;
        logic              move_up;
        logic              move_valid;
        region_t           region;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/level_follow_hysteresis_stepper_unit.sv -----
// Level follower: hysteresis band decision, step size choice and lost counter.
//
//   channel   direction  payload                              transfer when
//   s_axis    in         cap_sample                           s_tvalid & s_tready
//   m_axis    out        region .. lost_level (29 bits)       m_tvalid & m_tready
//   cfg       in         cfg_index, cfg_data                  cfg_valid & cfg_ready
//
// One sample per cycle while m_tready does not stall: an input register, compare and
// count logic, and a result register; m_tvalid rises when a sample moves from the input
// register into the result register.
// The lost counter lives in one register updated as a sample enters the result
// register. aresetn (synchronous) restores register defaults and clears the
// counter. A stall on m_tready holds the result and fills the input register.
`default_nettype none
`include "level_follow_hysteresis_stepper_unit_defines.svh"

module level_follow_hysteresis_stepper_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // sample stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,   // [23:0] cap_sample
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] region, [2] move_valid, [3] move_up, [11:4] step_length,
    // [12] rescan_request, [28:13] lost_level, [31:29] zero
    output logic [31:0]                        m_tdata,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lfhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lfhs_pkg::CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers
    logic [lfhs_pkg::CAP_W-1:0]  zero_level_reg;
    logic [lfhs_pkg::THR_W-1:0]  wet_threshold_reg;
    logic [lfhs_pkg::THR_W-1:0]  hysteresis_reg;
    logic [lfhs_pkg::CAP_W-1:0]  saturation_limit_reg;
    logic [lfhs_pkg::LOST_W-1:0] lost_limit_reg;
    logic [lfhs_pkg::STEP_W-1:0] step_small_reg;
    logic [lfhs_pkg::STEP_W-1:0] step_medium_reg;
    logic [lfhs_pkg::STEP_W-1:0] step_big_reg;

    // Pipeline registers
    logic                        in_valid_reg;
    logic [lfhs_pkg::CAP_W-1:0]  cap_reg;
    logic                        out_valid_reg;
    lfhs_pkg::result_t           out_reg;
    lfhs_pkg::result_t           out_next;
    logic [lfhs_pkg::LOST_W-1:0] lost_cnt_reg;
    logic [lfhs_pkg::LOST_W-1:0] lost_cnt_next;

    logic out_adv;
    logic in_adv;

    // Decision datapath
    logic signed [26:0] cap_w;
    logic signed [26:0] th_w;
    logic signed [26:0] tl_w;
    logic signed [26:0] dev_w;
    logic [25:0]        dev;
    logic [29:0]        dev10;
    logic [29:0]        thr8;
    logic [29:0]        thr3;
    logic               sat;
    logic               above;
    logic               below;
    logic               far_dev;
    logic [lfhs_pkg::LOST_W-1:0] cnt_mid;

    // Handshake: result register frees on transfer, input register follows
    assign out_adv   = !out_valid_reg || m_tready;
    assign in_adv    = in_valid_reg && out_adv;
    assign s_tready  = !in_valid_reg || out_adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};
    assign cfg_ready = 1'b1;

    // Configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_level_reg       <= '0;
            wet_threshold_reg    <= '0;
            hysteresis_reg       <= '0;
            saturation_limit_reg <= lfhs_pkg::RST_SATURATION_LIMIT;
            lost_limit_reg       <= lfhs_pkg::RST_LOST_LIMIT;
            step_small_reg       <= lfhs_pkg::RST_STEP_SMALL;
            step_medium_reg      <= lfhs_pkg::RST_STEP_MEDIUM;
            step_big_reg         <= lfhs_pkg::RST_STEP_BIG;
        end else if (cfg_valid) begin
            case (cfg_index)
                lfhs_pkg::REG_ZERO_LEVEL:       zero_level_reg <= cfg_data;
                lfhs_pkg::REG_WET_THRESHOLD:    wet_threshold_reg <= cfg_data[19:0];
                lfhs_pkg::REG_HYSTERESIS:       hysteresis_reg <= cfg_data[19:0];
                lfhs_pkg::REG_SATURATION_LIMIT: saturation_limit_reg <= cfg_data;
                lfhs_pkg::REG_LOST_LIMIT:       lost_limit_reg <= cfg_data[15:0];
                lfhs_pkg::REG_STEP_SMALL:       step_small_reg <= cfg_data[7:0];
                lfhs_pkg::REG_STEP_MEDIUM:      step_medium_reg <= cfg_data[7:0];
                lfhs_pkg::REG_STEP_BIG:         step_big_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Thresholds and deviation
    always_comb begin
        cap_w = signed'({3'b000, cap_reg});
        th_w  = signed'({3'b000, zero_level_reg}) + signed'({7'd0, wet_threshold_reg});
        tl_w  = th_w - signed'({7'd0, hysteresis_reg});
        sat   = cap_reg > saturation_limit_reg;
        above = cap_w >= th_w;
        below = cap_w <= tl_w;
        dev_w = above ? (cap_w - th_w) : (tl_w - cap_w);
        dev   = dev_w[25:0];
        dev10 = ({4'd0, dev} << 3) + ({4'd0, dev} << 1);
        thr8  = {7'd0, wet_threshold_reg, 3'b000};
        thr3  = {10'd0, wet_threshold_reg} + {9'd0, wet_threshold_reg, 1'b0};
        far_dev = dev >= {6'd0, wet_threshold_reg};
    end

    // Region, step choice and lost counter update
    always_comb begin
        out_next = '0;
        cnt_mid  = lost_cnt_reg;
        if (sat) begin
            out_next.region     = lfhs_pkg::REGION_SATURATED;
            out_next.move_valid = 1'b1;
            out_next.move_up    = 1'b1;
            out_next.step_length = step_big_reg;
            cnt_mid = (lost_cnt_reg == lfhs_pkg::LOST_MAX) ? lost_cnt_reg
                                                           : lost_cnt_reg + 16'd1;
        end else if (above || below) begin
            out_next.region     = above ? lfhs_pkg::REGION_ABOVE : lfhs_pkg::REGION_BELOW;
            out_next.move_valid = 1'b1;
            out_next.move_up    = above;
            priority if (dev10 > thr8) begin
                out_next.step_length = step_big_reg;
            end else if (dev10 > thr3) begin
                out_next.step_length = step_medium_reg;
            end else begin
                out_next.step_length = step_small_reg;
            end
            priority if (far_dev) begin
                cnt_mid = (lost_cnt_reg == lfhs_pkg::LOST_MAX) ? lost_cnt_reg
                                                               : lost_cnt_reg + 16'd1;
            end else if (lost_cnt_reg != '0) begin
                cnt_mid = lost_cnt_reg - 16'd1;
            end else begin
                cnt_mid = lost_cnt_reg;
            end
        end else begin
            out_next.region = lfhs_pkg::REGION_STABLE;
            cnt_mid = '0;
        end
        // on a move, request a re-search and clear once the limit is reached
        if (out_next.move_valid && (cnt_mid >= lost_limit_reg)) begin
            out_next.rescan_request = 1'b1;
            lost_cnt_next = '0;
        end else begin
            lost_cnt_next = cnt_mid;
        end
        out_next.lost_level = lost_cnt_next;
    end

    // Pipeline control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lost_cnt_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_adv) begin
                lost_cnt_reg <= lost_cnt_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cap_reg <= s_tdata;
        end
        if (in_adv) begin
            out_reg <= out_next;
        end
    end

    // Assertions
    `LFHS_ASSERT(a_cnt_matches_result,
                 in_adv |=> (out_reg.lost_level == lost_cnt_reg),
                 "lost counter and reported lost level differ")
    `LFHS_ASSERT(a_rescan_clears,
                 (out_valid_reg && out_reg.rescan_request) |-> (out_reg.lost_level == '0),
                 "re-search without counter clear")
    `LFHS_ASSERT(a_stable_no_move,
                 (out_valid_reg && out_reg.region == lfhs_pkg::REGION_STABLE)
                     |-> (!out_reg.move_valid && out_reg.lost_level == '0),
                 "stable band result moves or keeps count")
    `LFHS_ASSERT(a_idle_fields_zero,
                 (out_valid_reg && !out_reg.move_valid)
                     |-> (out_reg.step_length == '0 && !out_reg.rescan_request
                          && !out_reg.move_up),
                 "fields set without a move")

endmodule

`default_nettype wire

// ----- verif/tb_level_follow_hysteresis_stepper_unit.sv -----
// Self-checking testbench for the level follower: predicted probe moves against the stream.
`timescale 1ns / 100ps

module tb_level_follow_hysteresis_stepper_unit;
    import lfhs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // Index outside the register map; the block must ignore a write to it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

    // Predicts each probe move from the samples seen and holds the moves still owed
    class probe_move_predictor;
        logic [CAP_W-1:0]  zero_lvl;
        logic [THR_W-1:0]  wet_thr;
        logic [THR_W-1:0]  hyst_w;
        logic [CAP_W-1:0]  sat_lim;
        logic [LOST_W-1:0] lost_lim;
        logic [STEP_W-1:0] step_sm;
        logic [STEP_W-1:0] step_md;
        logic [STEP_W-1:0] step_bg;
        logic [LOST_W-1:0] lost_cnt;
        result_t           expected_moves[$];
        int                fail_count;

        function new();
            zero_lvl   = '0;
            wet_thr    = '0;
            hyst_w     = '0;
            sat_lim    = RST_SATURATION_LIMIT;
            lost_lim   = RST_LOST_LIMIT;
            step_sm    = RST_STEP_SMALL;
            step_md    = RST_STEP_MEDIUM;
            step_bg    = RST_STEP_BIG;
            lost_cnt   = '0;
            fail_count = 0;
        endfunction

        function void flag(string what);
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH: %s", what);
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_ZERO_LEVEL:       zero_lvl = data;
                REG_WET_THRESHOLD:    wet_thr  = data[THR_W-1:0];
                REG_HYSTERESIS:       hyst_w   = data[THR_W-1:0];
                REG_SATURATION_LIMIT: sat_lim  = data;
                REG_LOST_LIMIT:       lost_lim = data[LOST_W-1:0];
                REG_STEP_SMALL:       step_sm  = data[STEP_W-1:0];
                REG_STEP_MEDIUM:      step_md  = data[STEP_W-1:0];
                REG_STEP_BIG:         step_bg  = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // Saturating increment of the lost counter
        function logic [LOST_W-1:0] bump(logic [LOST_W-1:0] c);
            return (c == LOST_MAX) ? LOST_MAX : c + 1'b1;
        endfunction

        // Decide the move for one accepted sample and queue it
        function void note_sample(logic [CAP_W-1:0] cap);
            longint  c;
            longint  th;
            longint  tl;
            longint  t;
            longint  d;
            result_t r;
            c  = longint'(cap);
            th = longint'(zero_lvl) + longint'(wet_thr);
            tl = th - longint'(hyst_w);
            t  = longint'(wet_thr);
            d  = 0;
            r  = '0;
            if (c > longint'(sat_lim)) begin
                r.region      = REGION_SATURATED;
                r.move_valid  = 1'b1;
                r.move_up     = 1'b1;
                r.step_length = step_bg;
                lost_cnt      = bump(lost_cnt);
            end else if (c >= th || c <= tl) begin
                if (c >= th) begin
                    r.region  = REGION_ABOVE;
                    r.move_up = 1'b1;
                    d         = c - th;
                end else begin
                    r.region  = REGION_BELOW;
                    d         = tl - c;
                end
                r.move_valid = 1'b1;
                if (10 * d > 8 * t)
                    r.step_length = step_bg;
                else if (10 * d > 3 * t)
                    r.step_length = step_md;
                else
                    r.step_length = step_sm;
                if (d >= t)
                    lost_cnt = bump(lost_cnt);
                else if (lost_cnt != 0)
                    lost_cnt = lost_cnt - 1'b1;
            end else begin
                r.region = REGION_STABLE;
                lost_cnt = '0;
            end
            // Ask for a full re-search once the surface is lost for too long
            if (r.move_valid && lost_cnt >= lost_lim) begin
                r.rescan_request = 1'b1;
                lost_cnt         = '0;
            end
            r.lost_level = lost_cnt;
            expected_moves.push_back(r);
        endfunction

        // Compare one result transfer against the oldest predicted move
        function void check_move(logic [31:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[28:0]);
            if (expected_moves.size() == 0) begin
                flag($sformatf("unexpected result %h", data));
                return;
            end
            want = expected_moves.pop_front();
            if (got != want || data[31:29] != 3'b000)
                flag($sformatf({"expected region=%0d valid=%0d up=%0d step=%0d rescan=%0d ",
                                "lost=%0d, got region=%0d valid=%0d up=%0d step=%0d ",
                                "rescan=%0d lost=%0d pad=%0d"},
                               want.region, want.move_valid, want.move_up,
                               want.step_length, want.rescan_request, want.lost_level,
                               got.region, got.move_valid, got.move_up,
                               got.step_length, got.rescan_request, got.lost_level,
                               data[31:29]));
        endfunction

        function void finish_check();
            result_t left;
            while (expected_moves.size() != 0) begin
                left = expected_moves.pop_front();
                flag($sformatf("move never arrived: region=%0d lost=%0d",
                               left.region, left.lost_level));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    probe_move_predictor sb;
    bit                  steady_flow;
    int                  cycle_count = 0;

    level_follow_hysteresis_stepper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watch every transfer on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_sample(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_move(m_tdata);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("level_follow_hysteresis_stepper_unit test failed");
            $finish;
        end
    end

    // Mostly short idle gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            g = idle_gap();
            if (g > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (g - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] z, input logic [23:0] w, input logic [23:0] h,
                             input logic [23:0] s, input logic [23:0] ll, input logic [23:0] sm,
                             input logic [23:0] md, input logic [23:0] bg);
        write_reg(REG_ZERO_LEVEL, z);
        write_reg(REG_WET_THRESHOLD, w);
        write_reg(REG_HYSTERESIS, h);
        write_reg(REG_SATURATION_LIMIT, s);
        write_reg(REG_LOST_LIMIT, ll);
        write_reg(REG_STEP_SMALL, sm);
        write_reg(REG_STEP_MEDIUM, md);
        write_reg(REG_STEP_BIG, bg);
    endtask

    // Offer one sample, optionally after an idle gap, and hold it until the transfer
    task automatic send_sample(input logic [23:0] v);
        int g;
        g = idle_gap();
        if (g > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop the sample stream and wait until every predicted move has come back
    task automatic wait_drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_random_setting();
        int unsigned z;
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned ll;
        if ($urandom_range(0, 3) == 0) begin
            write_all(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        end else begin
            z  = $urandom_range(0, 24'hF00000);
            w  = $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 20'hFFFFF);
            h  = $urandom_range(0, w + 10);
            s  = z + 3 * w + $urandom_range(0, 100000);
            if (s > 24'hFFFFFF)
                s = 24'hFFFFFF;
            ll = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            write_all(24'(z), 24'(w), 24'(h), 24'(s), 24'(ll),
                      24'($urandom), 24'($urandom), 24'($urandom));
        end
    endtask

    // Draw a sample of the given kind around the current thresholds
    function automatic logic [23:0] pick_sample(int kind);
        longint th;
        longint tl;
        longint t;
        longint h;
        longint v;
        th = longint'(sb.zero_lvl) + longint'(sb.wet_thr);
        t  = longint'(sb.wet_thr);
        h  = longint'(sb.hyst_w);
        tl = th - h;
        case (kind)
            0: v = th + longint'($urandom_range(0, 32'(2 * t + 2)));
            1: v = tl - longint'($urandom_range(0, 32'(2 * t + 2)));
            2: begin
                if (h > 1)
                    v = tl + 1 + longint'($urandom_range(0, 32'(h - 2)));
                else
                    v = th;
            end
            3: begin
                if ($urandom_range(0, 1))
                    v = th + t + longint'($urandom_range(0, 32'(t + 1000)));
                else
                    v = tl - t - longint'($urandom_range(0, 32'(t + 1000)));
            end
            4: v = longint'(sb.sat_lim) + 1 + longint'($urandom_range(0, 1000));
            default: v = longint'($urandom_range(0, 24'hFFFFFF));
        endcase
        if (v < 0)
            v = 0;
        if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
        return v[23:0];
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 0;
        if (r < 50)
            return 1;
        if (r < 65)
            return 2;
        if (r < 82)
            return 3;
        if (r < 92)
            return 4;
        return 5;
    endfunction

    initial begin
        int  kind;
        int  run;
        int  sent;
        bit  paused;
        sb          = new();
        steady_flow = 1'b0;
        paused      = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Reset settings: both thresholds at zero, so every sample is a move, a big step unless it is zero
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_sample(24'd9999000);
        send_sample(24'd9999001);
        wait_drain();

        // Typical band: upper 1200000, lower 1150000, step boundaries and a re-search
        write_all(24'd1000000, 24'd200000, 24'd50000, 24'd9999000, 24'd5, 24'd2, 24'd10, 24'd50);
        send_sample(24'd1199999);
        send_sample(24'd1150001);
        send_sample(24'd1200000);
        send_sample(24'd1260000);
        send_sample(24'd1260001);
        send_sample(24'd1360000);
        send_sample(24'd1360001);
        send_sample(24'd1150000);
        send_sample(24'd1400000);
        send_sample(24'd950000);
        send_sample(24'hFFFFFF);
        send_sample(24'd0);
        send_sample(24'd9999000);
        wait_drain();

        // Zero threshold and zero lost limit: every move re-searches
        write_reg(REG_WET_THRESHOLD, 24'd0);
        write_reg(REG_HYSTERESIS, 24'd1000);
        write_reg(REG_LOST_LIMIT, 24'd0);
        send_sample(24'd1000000);
        send_sample(24'd1000001);
        send_sample(24'd999500);
        send_sample(24'd998995);
        wait_drain();

        // All registers at their maximum, plus a write to an unmapped index
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        write_reg(REG_SPARE, 24'h123456);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        wait_drain();

        // Lower threshold below zero: no below-band region exists
        write_all(24'd100, 24'd1000, 24'd5000, 24'd2000, 24'd3, 24'd7, 24'd77, 24'd177);
        send_sample(24'd0);
        send_sample(24'd1100);
        send_sample(24'd2001);
        wait_drain();

        // Random settings with runs of one sample kind to drive the lost counter
        for (int ph = 0; ph < 8; ph++) begin
            steady_flow = (ph == 2 || ph == 5);
            apply_random_setting();
            sent = 0;
            while (sent < 112) begin
                kind = pick_kind();
                run  = $urandom_range(1, 10);
                repeat (run) begin
                    send_sample(pick_sample(kind));
                    sent++;
                end
                if (ph == 3 && sent >= 60 && !paused) begin
                    wait_drain();
                    paused = 1'b1;
                end
            end
            wait_drain();
        end
        steady_flow = 1'b0;

        repeat (12) @(posedge aclk);
        sb.finish_check();
        if (sb.fail_count == 0)
            $display("level_follow_hysteresis_stepper_unit test passed");
        else
            $display("level_follow_hysteresis_stepper_unit test failed");
        $finish;
    end

endmodule
